FILE: rtl/core/pcbc_pkg.sv
// ----------------------------------------------------------------------------
// pcbc_pkg
// Shared types and constants of the per-class batch coalescer.
// ----------------------------------------------------------------------------
package pcbc_pkg;

   localparam int WORD_W       = 64;
   localparam int TIME_W       = 63;
   localparam int CLASS_W      = 2;
   localparam int CMD_W        = 2;
   localparam int SIZE_W       = 4;
   localparam int WIN_W        = 32;
   localparam int NUM_WIN_REGS = 4;
   localparam int NS_PER_US    = 1000;
   localparam int LIMIT_W      = 42;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH      = 2'd0,
      CMD_TICK      = 2'd1,
      CMD_FLUSH_ALL = 2'd2
   } cmd_type;

   typedef enum logic {
      KIND_REPLY = 1'b0,
      KIND_DRAIN = 1'b1
   } kind_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [CLASS_W-1:0]  action_class;
      logic [WORD_W-1:0]   request_word;
      logic [TIME_W-1:0]   now_time_ns;
   } cmd_item_type;

   typedef struct packed {
      kind_type            result_kind;
      logic [CLASS_W-1:0]  result_class;
      logic [WORD_W-1:0]   batch_number;
      logic                no_signal;
      logic [WORD_W-1:0]   drained_word;
      logic [SIZE_W-1:0]   batch_size;
      logic [TIME_W-1:0]   flush_time_ns;
      logic                batch_end;
      logic                last;
   } rsp_item_type;

   typedef struct packed {
      logic [NUM_WIN_REGS-1:0]              zero;
      logic [NUM_WIN_REGS-1:0][LIMIT_W-1:0] limit;
   } win_cfg_type;

endpackage

FILE: rtl/core/pcbc_if.sv
// ----------------------------------------------------------------------------
// pcbc_if
// Request and response channel interfaces of the batch coalescer.
// ----------------------------------------------------------------------------
interface pcbc_req_if import pcbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [CLASS_W-1:0]  action_class;
   logic [WORD_W-1:0]   request_word;
   logic [TIME_W-1:0]   now_time_ns;

   modport source (output valid, command, action_class, request_word, now_time_ns,
                   input ready);
   modport sink   (input valid, command, action_class, request_word, now_time_ns,
                   output ready);
endinterface

interface pcbc_rsp_if import pcbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                result_kind;
   logic [CLASS_W-1:0]  result_class;
   logic [WORD_W-1:0]   batch_number;
   logic                no_signal;
   logic [WORD_W-1:0]   drained_word;
   logic [SIZE_W-1:0]   batch_size;
   logic [TIME_W-1:0]   flush_time_ns;
   logic                batch_end;
   logic                last;

   modport source (output valid, result_kind, result_class, batch_number, no_signal,
                   drained_word, batch_size, flush_time_ns, batch_end, last,
                   input ready);
   modport sink   (input valid, result_kind, result_class, batch_number, no_signal,
                   drained_word, batch_size, flush_time_ns, batch_end, last,
                   output ready);
endinterface

FILE: rtl/core/pcbc_ram.sv
// ----------------------------------------------------------------------------
// pcbc_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module pcbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/pcbc_csr.sv
// ----------------------------------------------------------------------------
// pcbc_csr
// Window registers; keeps each window pre-scaled to nanoseconds.
// ----------------------------------------------------------------------------
module pcbc_csr import pcbc_pkg::*; #(
   parameter int CLASSES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output win_cfg_type           cfg
);
   logic [NUM_WIN_REGS-1:0][WIN_W-1:0]   win_ff,   win_in;
   logic [NUM_WIN_REGS-1:0][LIMIT_W-1:0] limit_ff, limit_in;
   logic [1:0]                           idx;
   logic                                 wr;

   assign idx    = paddr[3:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = win_ff[idx];

   always_comb begin
      win_in   = win_ff;
      limit_in = limit_ff;
      if (wr && (32'(idx) < CLASSES)) begin
         win_in[idx]   = pwdata;
         limit_in[idx] = LIMIT_W'(pwdata) * LIMIT_W'(NS_PER_US);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         limit_ff <= '0;
      end else begin
         win_ff   <= win_in;
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_WIN_REGS; k++) begin
         cfg.zero[k]  = (win_ff[k] == '0);
         cfg.limit[k] = limit_ff[k];
      end
   end
endmodule

FILE: rtl/core/pcbc_front.sv
// ----------------------------------------------------------------------------
// pcbc_front
// Accept and classify commands; drop ones without effect; queue the rest.
// ----------------------------------------------------------------------------
module pcbc_front import pcbc_pkg::*; #(
   parameter int CLASSES = 4
) (
   input  logic          clock,
   input  logic          reset,
   pcbc_req_if.sink      req_bus,
   output logic          q_valid,
   output cmd_item_type  q_item,
   input  logic          q_pop
);
   cmd_item_type q_ff [2];
   cmd_item_type item;
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   count_ff, count_in;
   logic         keep;
   logic         push;

   assign req_bus.ready = (count_ff != 2'd2);

   always_comb begin
      item.cmd          = CMD_PUSH;
      item.action_class = req_bus.action_class;
      item.request_word = req_bus.request_word;
      item.now_time_ns  = req_bus.now_time_ns;
      keep              = 1'b0;
      unique case (req_bus.command)
         CMD_PUSH: begin
            item.cmd = CMD_PUSH;
            keep     = (32'(req_bus.action_class) < CLASSES);
         end
         CMD_TICK: begin
            item.cmd = CMD_TICK;
            keep     = 1'b1;
         end
         CMD_FLUSH_ALL: begin
            item.cmd = CMD_FLUSH_ALL;
            keep     = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign push    = req_bus.valid && req_bus.ready && keep;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ q_pop;
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= item;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end
endmodule

FILE: rtl/core/pcbc_engine.sv
// ----------------------------------------------------------------------------
// pcbc_engine
// Per-class ring state, batch sequencing and drain of flushed batches.
// ----------------------------------------------------------------------------
module pcbc_engine import pcbc_pkg::*; #(
   parameter int CLASSES  = 4,
   parameter int CAPACITY = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_item_type  q_item,
   output logic          q_pop,
   input  win_cfg_type   cfg,
   pcbc_rsp_if.source    rsp_bus
);
   localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int PW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CLASSES * CAPACITY);

   typedef enum logic [1:0] {ST_IDLE, ST_PICK, ST_DRAIN, ST_REPLY} state_type;

   state_type                   state_ff, state_in;
   logic [PW-1:0]               rp_ff    [CLASSES];
   logic [PW-1:0]               rp_in    [CLASSES];
   logic [FW-1:0]               fill_ff  [CLASSES];
   logic [FW-1:0]               fill_in  [CLASSES];
   logic [TIME_W-1:0]           open_ff  [CLASSES];
   logic [TIME_W-1:0]           open_in  [CLASSES];
   logic [WORD_W-1:0]           lastb_ff [CLASSES];
   logic [WORD_W-1:0]           lastb_in [CLASSES];
   logic [WORD_W-1:0]           seq_ff,   seq_in;
   logic [CLASSES-1:0]          mask_ff,  mask_in;
   logic                        reply_ff, reply_in;
   logic [CW-1:0]               cur_ff,   cur_in;
   logic [FW-1:0]               n_ff,     n_in;
   logic [PW-1:0]               base_ff,  base_in;
   logic [FW-1:0]               idx_ff,   idx_in;
   logic [WORD_W-1:0]           id_ff,    id_in;
   logic [TIME_W-1:0]           now_ff,   now_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_item_type                rsp_ff,   rsp_in;

   logic                        slot_free;
   logic [CLASSES-1:0]          eligible;
   logic [CLASSES-1:0]          nonempty;
   logic [CW-1:0]               pick;
   logic [CW-1:0]               pcls;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [WORD_W-1:0]           rd_data;
   logic                        end_of_batch;

   function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
                                              input logic [FW-1:0] b);
      logic [FW:0] sum;
      sum = (FW+1)'(a) + (FW+1)'(b);
      if (sum >= (FW+1)'(CAPACITY)) begin
         sum = sum - (FW+1)'(CAPACITY);
      end
      return PW'(sum);
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c,
                                               input logic [PW-1:0] s);
      return AW'(32'(c) * CAPACITY + 32'(s));
   endfunction

   pcbc_ram #(.WIDTH(WORD_W), .DEPTH(CLASSES * CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.request_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign pcls      = CW'(q_item.action_class);

   always_comb begin
      for (int c = 0; c < CLASSES; c++) begin
         logic              wzero;
         logic [TIME_W-1:0] diff;
         wzero       = (c < NUM_WIN_REGS) ? cfg.zero[c % NUM_WIN_REGS] : 1'b1;
         diff        = q_item.now_time_ns - open_ff[c];
         nonempty[c] = (fill_ff[c] != '0);
         eligible[c] = nonempty[c] &&
                       (wzero || ((q_item.now_time_ns >= open_ff[c]) &&
                        (diff >= TIME_W'(cfg.limit[c % NUM_WIN_REGS]))));
      end
   end

   always_comb begin
      pick = '0;
      for (int c = CLASSES - 1; c >= 0; c--) begin
         if (mask_ff[c]) begin
            pick = CW'(c);
         end
      end
   end

   assign end_of_batch = ((idx_ff + 1'b1) == n_ff);

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      open_in      = open_ff;
      lastb_in     = lastb_ff;
      seq_in       = seq_ff;
      mask_in      = mask_ff;
      reply_in     = reply_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_addr(pcls, ring_add(rp_ff[pcls], fill_ff[pcls]));
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop  = 1'b1;
               now_in = q_item.now_time_ns;
               unique case (q_item.cmd)
                  CMD_PUSH: begin
                     wr_en         = 1'b1;
                     fill_in[pcls] = fill_ff[pcls] + 1'b1;
                     if (fill_ff[pcls] == '0) begin
                        open_in[pcls] = q_item.now_time_ns;
                     end
                     if ((fill_ff[pcls] + 1'b1) == FW'(CAPACITY)) begin
                        mask_in       = '0;
                        mask_in[pcls] = 1'b1;
                        reply_in      = 1'b1;
                        state_in      = ST_PICK;
                     end else begin
                        rsp_valid_in        = 1'b1;
                        rsp_in              = '0;
                        rsp_in.result_kind  = KIND_REPLY;
                        rsp_in.result_class = q_item.action_class;
                        rsp_in.batch_number = lastb_ff[pcls];
                        rsp_in.last         = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     mask_in  = eligible;
                     reply_in = 1'b0;
                     state_in = ST_PICK;
                  end
                  CMD_FLUSH_ALL: begin
                     mask_in  = nonempty;
                     reply_in = 1'b0;
                     state_in = ST_PICK;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PICK: begin
            if (mask_ff == '0) begin
               state_in = reply_ff ? ST_REPLY : ST_IDLE;
            end else begin
               cur_in         = pick;
               n_in           = fill_ff[pick];
               base_in        = rp_ff[pick];
               id_in          = seq_ff;
               seq_in         = seq_ff + 1'b1;
               lastb_in[pick] = seq_ff;
               rp_in[pick]    = ring_add(rp_ff[pick], fill_ff[pick]);
               fill_in[pick]  = '0;
               mask_in[pick]  = 1'b0;
               idx_in         = '0;
               rd_en          = 1'b1;
               rd_addr        = slot_addr(pick, rp_ff[pick]);
               state_in       = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_kind   = KIND_DRAIN;
               rsp_in.result_class  = CLASS_W'(cur_ff);
               rsp_in.batch_number  = id_ff;
               rsp_in.no_signal     = 1'b0;
               rsp_in.drained_word  = rd_data;
               rsp_in.batch_size    = SIZE_W'(n_ff);
               rsp_in.flush_time_ns = now_ff;
               rsp_in.batch_end     = end_of_batch;
               rsp_in.last          = end_of_batch && (mask_ff == '0) && !reply_ff;
               idx_in               = idx_ff + 1'b1;
               if (end_of_batch) begin
                  state_in = ST_PICK;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot_addr(cur_ff, ring_add(base_ff, idx_ff + 1'b1));
               end
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.result_kind  = KIND_REPLY;
               rsp_in.result_class = CLASS_W'(cur_ff);
               rsp_in.no_signal    = 1'b1;
               rsp_in.last         = 1'b1;
               reply_in            = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      n_ff    <= n_in;
      base_ff <= base_in;
      idx_ff  <= idx_in;
      id_ff   <= id_in;
      now_ff  <= now_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         mask_ff      <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CLASSES; c++) begin
            rp_ff[c]    <= '0;
            fill_ff[c]  <= '0;
            open_ff[c]  <= '0;
            lastb_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         mask_ff      <= mask_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         open_ff      <= open_in;
         lastb_ff     <= lastb_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.result_kind   = rsp_ff.result_kind;
   assign rsp_bus.result_class  = rsp_ff.result_class;
   assign rsp_bus.batch_number  = rsp_ff.batch_number;
   assign rsp_bus.no_signal     = rsp_ff.no_signal;
   assign rsp_bus.drained_word  = rsp_ff.drained_word;
   assign rsp_bus.batch_size    = rsp_ff.batch_size;
   assign rsp_bus.flush_time_ns = rsp_ff.flush_time_ns;
   assign rsp_bus.batch_end     = rsp_ff.batch_end;
   assign rsp_bus.last          = rsp_ff.last;
endmodule

FILE: rtl/core/per_class_batch_coalescer.sv
// ----------------------------------------------------------------------------
// per_class_batch_coalescer
// Per-class request batching with count and time-window flush.
//
// req_bus carries push, tick and flush-all commands; rsp_bus returns push
// replies and the drained requests of flushed batches, with last marking the
// final result of each command. csr_* is an APB write/read port for the four
// window registers (byte address 4*i), to be written while the block is idle.
// Commands enter a two-entry queue; a sequencer behind it updates class
// state. A push without a flush returns its reply in the cycle after it
// leaves the queue. A flush selects the class, then drains one request per
// cycle while rsp_bus takes them, set by the single read port of the request
// store; a tick or flush-all ends with a select step that finds no class
// left. New commands wait in the queue meanwhile. When rsp_bus stalls, the
// result register holds and the sequencer pauses. Reset clears all class
// state, the batch sequence and the windows; the request store is not cleared.
// ----------------------------------------------------------------------------
module per_class_batch_coalescer import pcbc_pkg::*; #(
   parameter int CLASSES  = 4,
   parameter int CAPACITY = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   pcbc_req_if.sink              req_bus,
   pcbc_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   logic         q_valid;
   logic         q_pop;
   cmd_item_type q_item;
   win_cfg_type  cfg;

   pcbc_csr #(.CLASSES(CLASSES)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pcbc_front #(.CLASSES(CLASSES)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   pcbc_engine #(.CLASSES(CLASSES), .CAPACITY(CAPACITY)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .cfg     (cfg),
      .rsp_bus (rsp_bus)
   );
endmodule

FILE: verif/tb_per_class_batch_coalescer.sv
// ----------------------------------------------------------------------------
// tb_per_class_batch_coalescer
// Self-checking testbench of the per-class batch coalescer. A cycle-free
// model of the class buffers predicts every push reply and drained request;
// a monitor compares each response transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_per_class_batch_coalescer;
   import pcbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCLS = 4;
   localparam int CAP  = 8;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pcbc_req_if req_bus ();
   pcbc_rsp_if rsp_bus ();

   per_class_batch_coalescer #(.CLASSES(NCLS), .CAPACITY(CAP)) i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [WORD_W-1:0] class_words [NCLS][CAP];
   int unsigned       class_fill [NCLS];
   logic [TIME_W-1:0] class_open [NCLS];
   logic [WORD_W-1:0] class_batch [NCLS];
   logic [WORD_W-1:0] batch_seq;
   logic [WIN_W-1:0]  window_us [NCLS];
   rsp_item_type      pending_rsp [$];
   int                errors;
   bit                rsp_stall_en;
   int unsigned       hold_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void push_drain(int c, logic [TIME_W-1:0] now_ns,
                                      ref rsp_item_type rs[$]);
      rsp_item_type r;
      int unsigned  n;
      n = class_fill[c];
      if (n == 0) return;
      for (int i = 0; i < n; i++) begin
         r = '0;
         r.result_kind   = KIND_DRAIN;
         r.result_class  = CLASS_W'(c);
         r.batch_number  = batch_seq;
         r.drained_word  = class_words[c][i];
         r.batch_size    = SIZE_W'(n);
         r.flush_time_ns = now_ns;
         r.batch_end     = (i == n - 1);
         rs.push_back(r);
      end
      class_batch[c] = batch_seq;
      batch_seq      = batch_seq + 1;
      class_fill[c]  = 0;
   endfunction

   function automatic void predict_cmd(cmd_item_type it);
      rsp_item_type rs[$];
      rsp_item_type r;
      int           c;
      logic [63:0]  limit;
      c = it.action_class;
      if (it.cmd == CMD_PUSH) begin
         if (class_fill[c] == 0) class_open[c] = it.now_time_ns;
         class_words[c][class_fill[c]] = it.request_word;
         class_fill[c]++;
         r = '0;
         r.result_kind  = KIND_REPLY;
         r.result_class = CLASS_W'(c);
         if (class_fill[c] >= CAP) begin
            push_drain(c, it.now_time_ns, rs);
            r.no_signal = 1'b1;
         end else begin
            r.batch_number = class_batch[c];
         end
         rs.push_back(r);
      end else if (it.cmd == CMD_TICK) begin
         for (int k = 0; k < NCLS; k++) begin
            limit = 64'(window_us[k]) * 64'd1000;
            if (class_fill[k] != 0 && (window_us[k] == 0 ||
                (it.now_time_ns >= class_open[k] &&
                 64'(it.now_time_ns - class_open[k]) >= limit)))
               push_drain(k, it.now_time_ns, rs);
         end
      end else if (it.cmd == CMD_FLUSH_ALL) begin
         for (int k = 0; k < NCLS; k++) push_drain(k, it.now_time_ns, rs);
      end
      if (rs.size() > 0) rs[rs.size() - 1].last = 1'b1;
      foreach (rs[i]) pending_rsp.push_back(rs[i]);
   endfunction

   task automatic send_cmd(logic [1:0] cmd, int c, logic [WORD_W-1:0] w,
                           logic [TIME_W-1:0] t);
      cmd_item_type it;
      repeat (gap_len()) @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.command      = cmd;
      req_bus.action_class = CLASS_W'(c);
      req_bus.request_word = w;
      req_bus.now_time_ns  = t;
      do @(posedge clock); while (!req_bus.ready);
      it.cmd          = cmd_type'(cmd);
      it.action_class = CLASS_W'(c);
      it.request_word = w;
      it.now_time_ns  = t;
      if (cmd != 2'd3) predict_cmd(it);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] v);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(4 * idx);
      csr_pwdata  = v;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      window_us[idx] = v;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_write_all(logic [31:0] w0, logic [31:0] w1,
                                logic [31:0] w2, logic [31:0] w3);
      wait_idle();
      csr_write(0, w0);
      csr_write(1, w1);
      csr_write(2, w2);
      csr_write(3, w3);
   endtask

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response transfer");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_bus.result_kind !== e.result_kind) begin
               $error("result_kind exp %0d got %0d", e.result_kind, rsp_bus.result_kind);
               errors++;
            end
            if (rsp_bus.result_class !== e.result_class) begin
               $error("result_class exp %0d got %0d", e.result_class, rsp_bus.result_class);
               errors++;
            end
            if (rsp_bus.batch_number !== e.batch_number) begin
               $error("batch_number exp %h got %h", e.batch_number, rsp_bus.batch_number);
               errors++;
            end
            if (rsp_bus.no_signal !== e.no_signal) begin
               $error("no_signal exp %0d got %0d", e.no_signal, rsp_bus.no_signal);
               errors++;
            end
            if (rsp_bus.drained_word !== e.drained_word) begin
               $error("drained_word exp %h got %h", e.drained_word, rsp_bus.drained_word);
               errors++;
            end
            if (rsp_bus.batch_size !== e.batch_size) begin
               $error("batch_size exp %0d got %0d", e.batch_size, rsp_bus.batch_size);
               errors++;
            end
            if (rsp_bus.flush_time_ns !== e.flush_time_ns) begin
               $error("flush_time_ns exp %h got %h", e.flush_time_ns,
                      rsp_bus.flush_time_ns);
               errors++;
            end
            if (rsp_bus.batch_end !== e.batch_end) begin
               $error("batch_end exp %0d got %0d", e.batch_end, rsp_bus.batch_end);
               errors++;
            end
            if (rsp_bus.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_bus.last);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!rsp_stall_en) begin
         rsp_bus.ready <= 1'b1;
         hold_cnt = 0;
      end else if (hold_cnt != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cnt--;
      end else if (r < 70) begin
         rsp_bus.ready <= 1'b1;
      end else if (r < 97) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b0;
         hold_cnt = $urandom_range(4, 30);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_directed();
      logic [TIME_W-1:0] t;
      t = 63'd1000;
      send_cmd(CMD_TICK, 0, '0, t);
      send_cmd(CMD_FLUSH_ALL, 0, '0, t);
      send_cmd(2'd3, 1, rand64(), t);
      send_cmd(CMD_PUSH, 0, 64'hFFFF_FFFF_FFFF_FFFF, t);
      send_cmd(CMD_PUSH, 3, 64'h0, '1);
      send_cmd(CMD_TICK, 0, '0, '1);
      for (int i = 0; i < CAP; i++) send_cmd(CMD_PUSH, 1, rand64(), t + i);
      send_cmd(CMD_PUSH, 1, rand64(), t);
      send_cmd(CMD_PUSH, 2, rand64(), 63'd0);
      send_cmd(CMD_FLUSH_ALL, 0, '0, '0);
   endtask

   task automatic test_windows();
      logic [TIME_W-1:0] t;
      csr_write_all(32'd1, 32'd5, 32'hFFFF_FFFF, 32'd0);
      t = 63'd50_000;
      for (int c = 0; c < NCLS; c++) send_cmd(CMD_PUSH, c, rand64(), t);
      send_cmd(CMD_TICK, 0, '0, t - 1);
      send_cmd(CMD_TICK, 0, '0, t + 999);
      send_cmd(CMD_TICK, 0, '0, t + 1000);
      send_cmd(CMD_TICK, 0, '0, t + 5000);
      send_cmd(CMD_TICK, 0, '0, '1);
      send_cmd(CMD_FLUSH_ALL, 0, '0, t);
   endtask

   task automatic test_random(int n, logic [31:0] wmax);
      logic [TIME_W-1:0] now_ns;
      int unsigned       r;
      csr_write_all($urandom_range(0, wmax), $urandom_range(0, wmax),
                    $urandom_range(0, wmax), $urandom_range(0, wmax));
      now_ns = {$urandom_range(0, 3) == 0, 62'($urandom())};
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) now_ns = now_ns - $urandom_range(0, 5000);
         else now_ns = now_ns + $urandom_range(0, 4000);
         if (r < 70) send_cmd(CMD_PUSH, $urandom_range(0, NCLS - 1), rand64(), now_ns);
         else if (r < 92) send_cmd(CMD_TICK, 0, rand64(), now_ns);
         else if (r < 97) send_cmd(CMD_FLUSH_ALL, $urandom_range(0, 3), rand64(), now_ns);
         else send_cmd(2'd3, $urandom_range(0, 3), rand64(), now_ns);
         if (i == n / 2) wait_idle();
      end
   endtask

   initial begin
      errors       = 0;
      rsp_stall_en = 1'b0;
      batch_seq    = '0;
      for (int c = 0; c < NCLS; c++) begin
         class_fill[c]  = 0;
         class_open[c]  = '0;
         class_batch[c] = '0;
         window_us[c]   = '0;
      end
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_bus.valid = 1'b0;
      req_bus.command      = '0;
      req_bus.action_class = '0;
      req_bus.request_word = '0;
      req_bus.now_time_ns  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      rsp_stall_en = 1'b1;
      test_windows();
      test_random(100, 32'd0);
      test_random(120, 32'd3);
      rsp_stall_en = 1'b0;
      test_random(100, 32'd10);
      rsp_stall_en = 1'b1;
      test_random(110, 32'hFFFF_FFFF);
      send_cmd(CMD_FLUSH_ALL, 0, '0, '0);
      wait_idle();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
